>>> rtl/core/hmf_pkg.sv
// hmf_pkg: shared constants and types for the HID message fragmenter.
// Used by hmf_ctrl, hmf_datapath and hid_message_fragmenter. No dependencies.

package hmf_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int MAX_MESSAGE  = 256;

    localparam int POS_W = $clog2(REPORT_BYTES);
    localparam int LEN_W = 9;
    localparam int SEQ_W = 7;
    localparam int HDR_W = 3;

    // last header byte index: init report (chan x4, cmd, len hi, len lo),
    // continuation report (chan x4, seq)
    localparam logic [HDR_W-1:0] HDR_INIT_LAST = 3'd6;
    localparam logic [HDR_W-1:0] HDR_CONT_LAST = 3'd4;

    localparam logic [HDR_W-1:0] HDR_CMD    = 3'd4;
    localparam logic [HDR_W-1:0] HDR_LEN_HI = 3'd5;

    // what the datapath loads into the output register this cycle
    localparam logic [2:0] EMIT_NONE = 3'd0;
    localparam logic [2:0] EMIT_ERR  = 3'd1;
    localparam logic [2:0] EMIT_HDR  = 3'd2;
    localparam logic [2:0] EMIT_DATA = 3'd3;
    localparam logic [2:0] EMIT_PAD  = 3'd4;

    typedef struct packed {
        logic       load;        // input beat accepted: capture data byte
        logic       start_msg;   // good first byte: latch header fields
        logic       start_cont;  // continuation report header begins
        logic [2:0] emit;
    } t_cmd;

    typedef struct packed {
        logic can_load;   // output register free this cycle
        logic active;     // message in progress
        logic pos_zero;   // next byte opens a report
        logic len_bad;    // incoming msg_len is zero or too long
        logic hdr_last;   // current header byte is the final one
        logic data_pad;   // emitting data ends message mid-report
        logic pos_eor;    // current byte closes a report
    } t_stat;

endpackage

>>> rtl/core/hid_message_fragmenter.sv
// hid_message_fragmenter: top level; cuts a response message into 64-byte
// HID reports. Depends on hmf_pkg, hmf_ctrl and hmf_datapath.
//
// One input beat is taken at a time. Each accepted beat causes report bytes,
// which go out through the output register: a
// plain data byte gives one output beat, the byte that opens a report adds
// its header (7 bytes on the first report, 5 on later ones), and the final
// message byte adds zero padding up to the report end; a dropped beat gives
// no output. The pace is set by the single output register, which takes one
// byte per cycle while the output is not stalled. A first byte with a length of
// zero or above 256 gives a single error beat; other bytes arriving with no
// message open are dropped.

module hid_message_fragmenter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_first_of_message,
    input  logic [7:0]                i_data_byte,
    input  logic [hmf_pkg::LEN_W-1:0] i_msg_len,
    input  logic [31:0]               i_channel_id,
    input  logic [7:0]                i_command,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_report_byte,
    output logic                      o_end_of_report,
    output logic                      o_last,
    output logic                      o_length_error
);

    hmf_pkg::t_cmd  cmd;
    hmf_pkg::t_stat stat;

    hmf_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_first_of_message (i_first_of_message),
        .i_stat             (stat),
        .o_cmd              (cmd),
        .o_in_stall         (o_in_stall)
    );

    hmf_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_data_byte        (i_data_byte),
        .i_msg_len          (i_msg_len),
        .i_channel_id       (i_channel_id),
        .i_command          (i_command),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_report_byte      (o_report_byte),
        .o_end_of_report    (o_end_of_report),
        .o_last             (o_last),
        .o_length_error     (o_length_error)
    );

endmodule

>>> rtl/core/hmf_ctrl.sv
// hmf_ctrl: sequencer for the fragmenter; decides per input beat which
// bytes get emitted. Depends on hmf_pkg.

module hmf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_first_of_message,
    input  hmf_pkg::t_stat i_stat,
    output hmf_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERR  = 3'd1;
    localparam logic [2:0] S_HDR  = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.emit       = hmf_pkg::EMIT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_first_of_message) begin
                        if (i_stat.len_bad) begin
                            n_state = S_ERR;
                        end else begin
                            o_cmd.start_msg = 1'b1;
                            n_state         = S_HDR;
                        end
                    end else if (i_stat.active) begin
                        if (i_stat.pos_zero) begin
                            o_cmd.start_cont = 1'b1;
                            n_state          = S_HDR;
                        end else begin
                            n_state = S_DATA;
                        end
                    end
                end
            end
            S_ERR: begin
                if (i_stat.can_load) begin
                    o_cmd.emit = hmf_pkg::EMIT_ERR;
                    n_state    = S_IDLE;
                end
            end
            S_HDR: begin
                if (i_stat.can_load) begin
                    o_cmd.emit = hmf_pkg::EMIT_HDR;
                    if (i_stat.hdr_last) n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (i_stat.can_load) begin
                    o_cmd.emit = hmf_pkg::EMIT_DATA;
                    n_state    = i_stat.data_pad ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                if (i_stat.can_load) begin
                    o_cmd.emit = hmf_pkg::EMIT_PAD;
                    if (i_stat.pos_eor) n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/hmf_datapath.sv
// hmf_datapath: report position, sequence and length tracking, header byte
// select and the output register. Depends on hmf_pkg.

module hmf_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hmf_pkg::t_cmd             i_cmd,
    output hmf_pkg::t_stat            o_stat,
    input  logic [7:0]                i_data_byte,
    input  logic [hmf_pkg::LEN_W-1:0] i_msg_len,
    input  logic [31:0]               i_channel_id,
    input  logic [7:0]                i_command,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic [7:0]                o_report_byte,
    output logic                      o_end_of_report,
    output logic                      o_last,
    output logic                      o_length_error
);

    logic [hmf_pkg::POS_W-1:0] r_pos;
    logic [hmf_pkg::SEQ_W-1:0] r_seq;
    logic [hmf_pkg::LEN_W-1:0] r_sent;
    logic [hmf_pkg::LEN_W-1:0] r_len;
    logic [31:0]               r_chan;
    logic [7:0]                r_cmd;
    logic [7:0]                r_data;
    logic [hmf_pkg::HDR_W-1:0] r_hidx;
    logic                      r_init_hdr;
    logic                      r_active;

    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_eor;
    logic                      r_out_last;
    logic                      r_out_err;

    logic                      eor;
    logic [hmf_pkg::POS_W-1:0] pos_inc;
    logic [hmf_pkg::LEN_W-1:0] sent_inc;
    logic                      msg_done;
    logic                      hdr_last;
    logic [7:0]                hdr_byte;
    logic                      emitting;

    assign eor      = (r_pos == hmf_pkg::POS_W'(hmf_pkg::REPORT_BYTES - 1));
    assign pos_inc  = eor ? '0 : r_pos + hmf_pkg::POS_W'(1);
    assign sent_inc = r_sent + hmf_pkg::LEN_W'(1);
    assign msg_done = (sent_inc >= r_len);
    assign hdr_last = r_init_hdr ? (r_hidx == hmf_pkg::HDR_INIT_LAST)
                                 : (r_hidx == hmf_pkg::HDR_CONT_LAST);
    assign emitting = (i_cmd.emit != hmf_pkg::EMIT_NONE);

    always_comb begin
        unique case (r_hidx)
            3'd0:    hdr_byte = r_chan[7:0];
            3'd1:    hdr_byte = r_chan[15:8];
            3'd2:    hdr_byte = r_chan[23:16];
            3'd3:    hdr_byte = r_chan[31:24];
            hmf_pkg::HDR_CMD:
                     hdr_byte = r_init_hdr ? r_cmd : {1'b0, r_seq};
            hmf_pkg::HDR_LEN_HI:
                     hdr_byte = 8'(r_len >> 8);
            default: hdr_byte = r_len[7:0];
        endcase
    end

    always_comb begin
        o_stat.can_load = !r_out_valid || !i_out_stall;
        o_stat.active   = r_active;
        o_stat.pos_zero = (r_pos == '0);
        o_stat.len_bad  = (i_msg_len == '0) ||
                          (i_msg_len > hmf_pkg::LEN_W'(hmf_pkg::MAX_MESSAGE));
        o_stat.hdr_last = hdr_last;
        o_stat.data_pad = msg_done && !eor;
        o_stat.pos_eor  = eor;
    end

    // message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_seq      <= '0;
            r_sent     <= '0;
            r_hidx     <= '0;
            r_init_hdr <= 1'b0;
            r_active   <= 1'b0;
        end else begin
            if (i_cmd.start_msg) begin
                r_pos      <= '0;
                r_seq      <= '0;
                r_sent     <= '0;
                r_hidx     <= '0;
                r_init_hdr <= 1'b1;
                r_active   <= 1'b1;
            end else if (i_cmd.start_cont) begin
                r_hidx     <= '0;
                r_init_hdr <= 1'b0;
            end
            unique case (i_cmd.emit)
                hmf_pkg::EMIT_ERR: begin
                    r_pos    <= '0;
                    r_seq    <= '0;
                    r_sent   <= '0;
                    r_active <= 1'b0;
                end
                hmf_pkg::EMIT_HDR: begin
                    r_pos  <= pos_inc;
                    r_hidx <= r_hidx + hmf_pkg::HDR_W'(1);
                    if (!r_init_hdr && hdr_last) r_seq <= r_seq + hmf_pkg::SEQ_W'(1);
                end
                hmf_pkg::EMIT_DATA: begin
                    r_pos <= pos_inc;
                    if (msg_done) begin
                        r_sent   <= '0;
                        r_seq    <= '0;
                        r_active <= 1'b0;
                    end else begin
                        r_sent <= sent_inc;
                    end
                end
                hmf_pkg::EMIT_PAD: begin
                    r_pos <= pos_inc;
                end
                default: begin
                end
            endcase
        end
    end

    // captured beat fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_data <= i_data_byte;
        if (i_cmd.start_msg) begin
            r_len  <= i_msg_len;
            r_chan <= i_channel_id;
            r_cmd  <= i_command;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emitting) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            hmf_pkg::EMIT_ERR: begin
                r_out_byte <= 8'h00;
                r_out_eor  <= 1'b0;
                r_out_last <= 1'b1;
                r_out_err  <= 1'b1;
            end
            hmf_pkg::EMIT_HDR: begin
                r_out_byte <= hdr_byte;
                r_out_eor  <= eor;
                r_out_last <= 1'b0;
                r_out_err  <= 1'b0;
            end
            hmf_pkg::EMIT_DATA: begin
                r_out_byte <= r_data;
                r_out_eor  <= eor;
                r_out_last <= !msg_done || eor;
                r_out_err  <= 1'b0;
            end
            hmf_pkg::EMIT_PAD: begin
                r_out_byte <= 8'h00;
                r_out_eor  <= eor;
                r_out_last <= eor;
                r_out_err  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_report_byte   = r_out_byte;
    assign o_end_of_report = r_out_eor;
    assign o_last          = r_out_last;
    assign o_length_error  = r_out_err;

    // sanity checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emitting |-> (!r_out_valid || !i_out_stall))
        else $error("beat loaded over a stalled output");

    a_sent_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_sent < r_len))
        else $error("message byte count ran past length");

    a_hdr_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit == hmf_pkg::EMIT_HDR) |-> r_active)
        else $error("header byte outside a message");

    a_pad_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit == hmf_pkg::EMIT_PAD) |-> (!r_active && r_pos != '0))
        else $error("padding while message still open");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= hmf_pkg::POS_W'(hmf_pkg::REPORT_BYTES - 1))
        else $error("report position out of range");

endmodule
